### src/ccl_pkg.sv
// ---------------------------------------------------------------------------
// ccl_pkg
// Operation codes, status codes and sequencer states of the cursor list unit.
// ---------------------------------------------------------------------------
package ccl_pkg;

	localparam logic [3:0] F_READ      = 4'd0;
	localparam logic [3:0] F_CLEAR     = 4'd1;
	localparam logic [3:0] F_FRONT     = 4'd2;
	localparam logic [3:0] F_BACK      = 4'd3;
	localparam logic [3:0] F_PREV      = 4'd4;
	localparam logic [3:0] F_NEXT      = 4'd5;
	localparam logic [3:0] F_PREPEND   = 4'd6;
	localparam logic [3:0] F_APPEND    = 4'd7;
	localparam logic [3:0] F_INSBEFORE = 4'd8;
	localparam logic [3:0] F_INSAFTER  = 4'd9;
	localparam logic [3:0] F_DELFRONT  = 4'd10;
	localparam logic [3:0] F_DELBACK   = 4'd11;
	localparam logic [3:0] F_DELCURSOR = 4'd12;
	localparam logic [3:0] F_SET       = 4'd13;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_NOCUR = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam int LEN_BITS  = 9;
	localparam int POS_BITS  = 9;
	localparam int WORD_BITS = 32;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_R1   = 10'b0000000010,
		S_G1   = 10'b0000000100,
		S_G2   = 10'b0000001000,
		S_W1   = 10'b0000010000,
		S_W2   = 10'b0000100000,
		S_D1   = 10'b0001000000,
		S_D2   = 10'b0010000000,
		S_D3   = 10'b0100000000,
		S_D4   = 10'b1000000000
	} state_t;

endpackage

### src/ccl_ram.sv
// ---------------------------------------------------------------------------
// ccl_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data (old data on a same-address collision).
// ---------------------------------------------------------------------------
module ccl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

### src/cursor_linked_list_manager_unit.sv
// ---------------------------------------------------------------------------
// cursor_linked_list_manager_unit
// Doubly linked list with cursor, held in node data / next / prev RAMs.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel: one beat per operation, func in s_tuser, data word in
//   s_tdata. Master channel: one result beat per operation with status,
//   length, cursor index (-1 when undefined) and cursor/front/back data.
//   Sequence: operations without link work (read, clear, cursor to front or
//   back, any failed operation) go from idle straight to the data reads;
//   link operations first pass the link read, gather and write states, and
//   insert-after with a non-empty free list adds a second gather state.
//   s_tready is high only while the sequencer is idle, so a new beat is not
//   taken until the last one is finished. The sequence is set by the single
//   read port of each node RAM: link reads, up to two write states, and
//   three sequential reads of the data RAM for the cursor, front and back words.
//   Reset: list empty, cursor undefined, free list empty, node RAMs hold
//   garbage that is never read before being written (fresh nodes are handed
//   out by a counter, so no clearing pass is needed).
//   Stall: a finished result sits in the output register; if it has not
//   been taken when the next one is ready, the sequencer holds in its last
//   state until m_tready frees the register.
// ---------------------------------------------------------------------------
module cursor_linked_list_manager_unit #(
	parameter int CAPACITY  = 256,
	parameter int DATA_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // value[31:0]
	input  logic [3:0]   s_tuser,   // func[3:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0], list_length[10:2], cursor_position[19:11],
	// cursor_data[51:20], front_data[83:52], back_data[115:84], zero pad
	output logic [119:0] m_tdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);

	ccl_pkg::state_t state_q;

	logic [3:0]           func_q;
	logic [DATA_BITS-1:0] val_q;
	logic [1:0]           st_q;
	logic [LW-1:0]        fresh_q, free_q, front_q, back_q, cur_q, cnt_q;
	logic [AW-1:0]        idx_q;
	logic [LW-1:0]        rp_q, rx_q, fn_q, m_q, pl_q, xl_q;
	logic [DATA_BITS-1:0] cd_q, fd_q;
	logic                 ov_q;
	logic [119:0]         od_q;

	// RAM ports
	logic                 d_we, p_we, n_we;
	logic [AW-1:0]        d_wa, p_wa, n_wa, d_ra, p_ra, n_ra;
	logic [DATA_BITS-1:0] d_wd, d_rd;
	logic [LW-1:0]        p_wd, n_wd, p_rd, n_rd;

	ccl_ram #(.WIDTH(DATA_BITS), .DEPTH(CAPACITY)) u_data (
		.clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
	);
	ccl_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
	);
	ccl_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next (
		.clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd)
	);

	// status of an incoming beat, from the current list state
	logic       empty, nocur, full;
	logic       need_elem, need_cur, is_add, link_op;
	logic [1:0] in_st;

	assign empty = (cnt_q == '0);
	assign nocur = (cur_q == NIL);
	assign full  = (cnt_q == NIL);

	always_comb begin
		need_elem = 1'b0;
		need_cur  = 1'b0;
		is_add    = 1'b0;
		case (s_tuser) inside
			ccl_pkg::F_FRONT, ccl_pkg::F_BACK, ccl_pkg::F_DELFRONT,
			ccl_pkg::F_DELBACK: need_elem = 1'b1;
			ccl_pkg::F_PREV, ccl_pkg::F_NEXT, ccl_pkg::F_DELCURSOR,
			ccl_pkg::F_SET: begin
				need_elem = 1'b1;
				need_cur  = 1'b1;
			end
			ccl_pkg::F_INSBEFORE, ccl_pkg::F_INSAFTER: begin
				need_elem = 1'b1;
				need_cur  = 1'b1;
				is_add    = 1'b1;
			end
			ccl_pkg::F_PREPEND, ccl_pkg::F_APPEND: is_add = 1'b1;
			default: ;
		endcase
		if (need_elem && empty)      in_st = ccl_pkg::ST_EMPTY;
		else if (need_cur && nocur)  in_st = ccl_pkg::ST_NOCUR;
		else if (is_add && full)     in_st = ccl_pkg::ST_FULL;
		else                         in_st = ccl_pkg::ST_OK;
		link_op = (in_st == ccl_pkg::ST_OK) && (s_tuser >= ccl_pkg::F_PREV)
			&& (s_tuser <= ccl_pkg::F_SET);
	end

	// per-operation link operands, from latched func and read results
	logic          q_add, q_del;
	logic [LW-1:0] add_p, add_x, new_m, del_n;

	always_comb begin
		q_add = 1'b0;
		q_del = 1'b0;
		add_p = NIL;
		add_x = NIL;
		del_n = cur_q;
		case (func_q)
			ccl_pkg::F_PREPEND: begin
				q_add = 1'b1;
				add_x = front_q;
			end
			ccl_pkg::F_APPEND: begin
				q_add = 1'b1;
				add_p = back_q;
			end
			ccl_pkg::F_INSBEFORE: begin
				q_add = 1'b1;
				add_p = rp_q;
				add_x = cur_q;
			end
			ccl_pkg::F_INSAFTER: begin
				q_add = 1'b1;
				add_p = cur_q;
				add_x = rx_q;
			end
			ccl_pkg::F_DELFRONT: begin
				q_del = 1'b1;
				del_n = front_q;
			end
			ccl_pkg::F_DELBACK: begin
				q_del = 1'b1;
				del_n = back_q;
			end
			ccl_pkg::F_DELCURSOR: q_del = 1'b1;
			default: ;
		endcase
		new_m = (free_q != NIL) ? free_q : fresh_q;
	end

	// RAM port control
	always_comb begin
		d_we = 1'b0;
		p_we = 1'b0;
		n_we = 1'b0;
		d_wa = new_m[AW-1:0];
		d_wd = val_q;
		p_wa = new_m[AW-1:0];
		p_wd = add_p;
		n_wa = new_m[AW-1:0];
		n_wd = add_x;
		d_ra = cur_q[AW-1:0];
		p_ra = q_del ? del_n[AW-1:0] : cur_q[AW-1:0];
		n_ra = free_q[AW-1:0];
		unique case (state_q)
			ccl_pkg::S_R1: begin
				if (q_del) n_ra = del_n[AW-1:0];
				else if (func_q == ccl_pkg::F_NEXT || func_q == ccl_pkg::F_INSAFTER)
					n_ra = cur_q[AW-1:0];
			end
			ccl_pkg::S_W1: begin
				if (q_add) begin
					d_we = 1'b1;
					p_we = 1'b1;
					n_we = 1'b1;
				end else if (q_del) begin
					// bridge the neighbors around the removed node
					n_we = (rp_q != NIL);
					n_wa = rp_q[AW-1:0];
					n_wd = rx_q;
					p_we = (rx_q != NIL);
					p_wa = rx_q[AW-1:0];
					p_wd = rp_q;
				end else if (func_q == ccl_pkg::F_SET) begin
					d_we = 1'b1;
					d_wa = cur_q[AW-1:0];
				end
			end
			ccl_pkg::S_W2: begin
				if (q_add) begin
					n_we = (pl_q != NIL);
					n_wa = pl_q[AW-1:0];
					n_wd = m_q;
					p_we = (xl_q != NIL);
					p_wa = xl_q[AW-1:0];
					p_wd = m_q;
				end else if (q_del) begin
					// push the removed node onto the free list
					n_we = 1'b1;
					n_wa = m_q[AW-1:0];
					n_wd = free_q;
				end
			end
			ccl_pkg::S_D2: d_ra = front_q[AW-1:0];
			ccl_pkg::S_D3, ccl_pkg::S_D4: d_ra = back_q[AW-1:0];
			default: ;
		endcase
	end

	logic out_free;
	assign out_free = !ov_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccl_pkg::S_IDLE;
			fresh_q <= '0;
			free_q  <= NIL;
			front_q <= NIL;
			back_q  <= NIL;
			cur_q   <= NIL;
			cnt_q   <= '0;
			idx_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			// in the last data state the load below owns the valid flag
			if (ov_q && m_tready && state_q != ccl_pkg::S_D4) ov_q <= 1'b0;
			unique case (state_q)
				ccl_pkg::S_IDLE: begin
					if (s_tvalid) begin
						func_q <= s_tuser;
						val_q  <= DATA_BITS'(s_tdata);
						st_q   <= in_st;
						if (in_st == ccl_pkg::ST_OK) begin
							case (s_tuser)
								ccl_pkg::F_CLEAR: begin
									fresh_q <= '0;
									free_q  <= NIL;
									front_q <= NIL;
									back_q  <= NIL;
									cnt_q   <= '0;
									cur_q   <= NIL;
									idx_q   <= '0;
								end
								ccl_pkg::F_FRONT: begin
									cur_q <= front_q;
									idx_q <= '0;
								end
								ccl_pkg::F_BACK: begin
									cur_q <= back_q;
									idx_q <= AW'(cnt_q - LW'(1));
								end
								default: ;
							endcase
						end
						state_q <= link_op ? ccl_pkg::S_R1 : ccl_pkg::S_D1;
					end
				end
				ccl_pkg::S_R1: state_q <= ccl_pkg::S_G1;
				ccl_pkg::S_G1: begin
					rp_q <= p_rd;
					rx_q <= n_rd;
					fn_q <= n_rd;
					// insert-after used the next port for the cursor link
					if (func_q == ccl_pkg::F_INSAFTER && free_q != NIL)
						state_q <= ccl_pkg::S_G2;
					else
						state_q <= ccl_pkg::S_W1;
				end
				ccl_pkg::S_G2: begin
					fn_q    <= n_rd;
					state_q <= ccl_pkg::S_W1;
				end
				ccl_pkg::S_W1: begin
					state_q <= ccl_pkg::S_W2;
					if (q_add) begin
						m_q  <= new_m;
						pl_q <= add_p;
						xl_q <= add_x;
						if (free_q != NIL) free_q <= fn_q;
						else               fresh_q <= fresh_q + LW'(1);
						if (add_p == NIL) front_q <= new_m;
						if (add_x == NIL) back_q <= new_m;
						cnt_q <= cnt_q + LW'(1);
						if (func_q == ccl_pkg::F_INSBEFORE ||
						    (func_q == ccl_pkg::F_PREPEND && cur_q != NIL))
							idx_q <= idx_q + AW'(1);
					end else if (q_del) begin
						m_q <= del_n;
						if (rp_q == NIL) front_q <= rx_q;
						if (rx_q == NIL) back_q <= rp_q;
						cnt_q <= cnt_q - LW'(1);
						case (func_q)
							ccl_pkg::F_DELFRONT: begin
								if (cur_q == front_q) begin
									cur_q <= NIL;
									idx_q <= '0;
								end else if (cur_q != NIL) begin
									idx_q <= idx_q - AW'(1);
								end
							end
							ccl_pkg::F_DELBACK: begin
								if (cur_q == back_q) begin
									cur_q <= NIL;
									idx_q <= '0;
								end
							end
							default: begin
								cur_q <= NIL;
								idx_q <= '0;
							end
						endcase
					end else if (func_q == ccl_pkg::F_PREV) begin
						if (cur_q == front_q) begin
							cur_q <= NIL;
							idx_q <= '0;
						end else begin
							cur_q <= rp_q;
							idx_q <= idx_q - AW'(1);
						end
					end else if (func_q == ccl_pkg::F_NEXT) begin
						if (cur_q == back_q) begin
							cur_q <= NIL;
							idx_q <= '0;
						end else begin
							cur_q <= rx_q;
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				ccl_pkg::S_W2: begin
					if (q_del) free_q <= m_q;
					state_q <= ccl_pkg::S_D1;
				end
				ccl_pkg::S_D1: state_q <= ccl_pkg::S_D2;
				ccl_pkg::S_D2: begin
					cd_q    <= (cur_q != NIL) ? d_rd : '0;
					state_q <= ccl_pkg::S_D3;
				end
				ccl_pkg::S_D3: begin
					fd_q    <= (front_q != NIL) ? d_rd : '0;
					state_q <= ccl_pkg::S_D4;
				end
				ccl_pkg::S_D4: begin
					if (out_free) begin
						ov_q <= 1'b1;
						od_q <= {4'd0,
							(back_q != NIL) ? ccl_pkg::WORD_BITS'(d_rd) : 32'd0,
							ccl_pkg::WORD_BITS'(fd_q),
							ccl_pkg::WORD_BITS'(cd_q),
							(cur_q == NIL) ? {ccl_pkg::POS_BITS{1'b1}}
								: ccl_pkg::POS_BITS'(idx_q),
							ccl_pkg::LEN_BITS'(cnt_q),
							st_q};
						state_q <= ccl_pkg::S_IDLE;
					end
				end
				default: state_q <= ccl_pkg::S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ccl_pkg::S_IDLE);
	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Checks the cursor list unit against a behavioral list model kept in the
// bench: directed corner operations, random operation mixes, fill to capacity
// and a long output hold-off so the unit backs up its input.
// ---------------------------------------------------------------------------
module tb;

	localparam int CAP = 256;
	localparam int NIL = CAP;

	// lowest field last: status sits in the low bits of the result beat
	typedef struct packed {
		logic [31:0] back_data;
		logic [31:0] front_data;
		logic [31:0] cur_data;
		logic [8:0]  cur_pos;
		logic [8:0]  length;
		logic [1:0]  status;
	} list_view_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [31:0]  s_tdata;   // value[31:0]
	logic [3:0]   s_tuser;   // func[3:0]
	logic         m_tvalid;
	logic         m_tready;
	logic [119:0] m_tdata;   // status, length, cursor pos, cursor/front/back data

	cursor_linked_list_manager_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// bench copy of the list
	logic [31:0] mdl_data [CAP];
	int          mdl_next [CAP];
	int          mdl_prev [CAP];
	int          fresh_cnt, free_hd, front_nd, back_nd, cur_nd, len, cur_idx;

	list_view_t  pending_views[$];
	int          errors;
	int          hold_off;    // long receiver stall request
	longint      cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic int grab_node();
		int n;
		if (free_hd != NIL) begin
			n = free_hd;
			free_hd = mdl_next[n];
		end else begin
			n = fresh_cnt;
			fresh_cnt++;
		end
		return n;
	endfunction

	function automatic void link_in(int p, int x, logic [31:0] v);
		int m;
		m = grab_node();
		mdl_data[m] = v;
		mdl_prev[m] = p;
		mdl_next[m] = x;
		if (p == NIL) front_nd = m; else mdl_next[p] = m;
		if (x == NIL) back_nd = m; else mdl_prev[x] = m;
		len++;
	endfunction

	function automatic void unlink(int n);
		int p, x;
		p = mdl_prev[n];
		x = mdl_next[n];
		if (p == NIL) front_nd = x; else mdl_next[p] = x;
		if (x == NIL) back_nd = p; else mdl_prev[x] = p;
		mdl_next[n] = free_hd;
		free_hd = n;
		len--;
	endfunction

	function automatic void lose_cursor();
		cur_nd = NIL;
		cur_idx = 0;
	endfunction

	function automatic logic [31:0] word_at(int n);
		return (n < NIL) ? mdl_data[n] : 32'd0;
	endfunction

	function automatic void list_reset();
		fresh_cnt = 0; free_hd = NIL; front_nd = NIL; back_nd = NIL;
		len = 0; lose_cursor();
	endfunction

	// applies one operation to the bench list and returns the expected view
	function automatic list_view_t list_apply(logic [3:0] op, logic [31:0] v);
		list_view_t r;
		logic [1:0] st;
		bit empty, nocur, full;
		st = ccl_pkg::ST_OK;
		empty = (len == 0);
		nocur = (cur_nd == NIL);
		full = (len >= CAP);
		case (op)
			ccl_pkg::F_CLEAR: list_reset();
			ccl_pkg::F_FRONT: begin
				if (empty) st = ccl_pkg::ST_EMPTY;
				else begin cur_nd = front_nd; cur_idx = 0; end
			end
			ccl_pkg::F_BACK: begin
				if (empty) st = ccl_pkg::ST_EMPTY;
				else begin cur_nd = back_nd; cur_idx = len - 1; end
			end
			ccl_pkg::F_PREV: begin
				if (empty) st = ccl_pkg::ST_EMPTY;
				else if (nocur) st = ccl_pkg::ST_NOCUR;
				else if (cur_nd == front_nd) lose_cursor();
				else begin cur_nd = mdl_prev[cur_nd]; cur_idx--; end
			end
			ccl_pkg::F_NEXT: begin
				if (empty) st = ccl_pkg::ST_EMPTY;
				else if (nocur) st = ccl_pkg::ST_NOCUR;
				else if (cur_nd == back_nd) lose_cursor();
				else begin cur_nd = mdl_next[cur_nd]; cur_idx++; end
			end
			ccl_pkg::F_PREPEND: begin
				if (full) st = ccl_pkg::ST_FULL;
				else begin
					link_in(NIL, front_nd, v);
					if (!nocur) cur_idx++;
				end
			end
			ccl_pkg::F_APPEND: begin
				if (full) st = ccl_pkg::ST_FULL;
				else link_in(back_nd, NIL, v);
			end
			ccl_pkg::F_INSBEFORE: begin
				if (empty) st = ccl_pkg::ST_EMPTY;
				else if (nocur) st = ccl_pkg::ST_NOCUR;
				else if (full) st = ccl_pkg::ST_FULL;
				else begin link_in(mdl_prev[cur_nd], cur_nd, v); cur_idx++; end
			end
			ccl_pkg::F_INSAFTER: begin
				if (empty) st = ccl_pkg::ST_EMPTY;
				else if (nocur) st = ccl_pkg::ST_NOCUR;
				else if (full) st = ccl_pkg::ST_FULL;
				else link_in(cur_nd, mdl_next[cur_nd], v);
			end
			ccl_pkg::F_DELFRONT: begin
				if (empty) st = ccl_pkg::ST_EMPTY;
				else begin
					if (cur_nd == front_nd) lose_cursor();
					else if (!nocur) cur_idx--;
					unlink(front_nd);
				end
			end
			ccl_pkg::F_DELBACK: begin
				if (empty) st = ccl_pkg::ST_EMPTY;
				else begin
					if (cur_nd == back_nd) lose_cursor();
					unlink(back_nd);
				end
			end
			ccl_pkg::F_DELCURSOR: begin
				if (empty) st = ccl_pkg::ST_EMPTY;
				else if (nocur) st = ccl_pkg::ST_NOCUR;
				else begin unlink(cur_nd); lose_cursor(); end
			end
			ccl_pkg::F_SET: begin
				if (empty) st = ccl_pkg::ST_EMPTY;
				else if (nocur) st = ccl_pkg::ST_NOCUR;
				else mdl_data[cur_nd] = v;
			end
			default: ;  // read and unused codes
		endcase
		r.status     = st;
		r.length     = len[8:0];
		r.cur_pos    = (cur_nd == NIL) ? 9'h1FF : cur_idx[8:0];
		r.cur_data   = word_at(cur_nd);
		r.front_data = word_at(front_nd);
		r.back_data  = word_at(back_nd);
		return r;
	endfunction

	// one beat on the slave side, with a random gap before it; tvalid stays
	// up between back-to-back beats and drops only for a gap
	task automatic send_op(logic [3:0] op, logic [31:0] v);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		pending_views.push_back(list_apply(op, v));
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int stall;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				m_tready <= 1'b0;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// result check on every accepted master beat
	always @(posedge clk) begin
		list_view_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[115:0];
			if (pending_views.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pending_views.pop_front();
				if (got.status !== want.status) begin
					$display("%0t status exp %0d got %0d", $time, want.status, got.status);
					errors++;
				end
				if (got.length !== want.length) begin
					$display("%0t length exp %0d got %0d", $time, want.length, got.length);
					errors++;
				end
				if (got.cur_pos !== want.cur_pos) begin
					$display("%0t cursor pos exp %h got %h", $time, want.cur_pos, got.cur_pos);
					errors++;
				end
				if (got.cur_data !== want.cur_data) begin
					$display("%0t cursor data exp %h got %h", $time, want.cur_data,
						got.cur_data);
					errors++;
				end
				if (got.front_data !== want.front_data) begin
					$display("%0t front data exp %h got %h", $time, want.front_data,
						got.front_data);
					errors++;
				end
				if (got.back_data !== want.back_data) begin
					$display("%0t back data exp %h got %h", $time, want.back_data,
						got.back_data);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// every code, starting on an empty list, then each corner on a short list
	task automatic test_directed();
		logic [3:0] op;
		for (int i = 0; i < 16; i++) begin
			op = 4'(i);
			send_op(op, 32'hFFFF_FFFF);
		end
		send_op(ccl_pkg::F_APPEND, 32'h0000_0001);
		send_op(ccl_pkg::F_PREPEND, 32'hFFFF_FFFF);   // cursor undefined ops below
		send_op(ccl_pkg::F_PREV, 32'd0);
		send_op(ccl_pkg::F_SET, 32'd5);
		send_op(ccl_pkg::F_FRONT, 32'd0);
		send_op(ccl_pkg::F_PREV, 32'd0);             // step off the front
		send_op(ccl_pkg::F_BACK, 32'd0);
		send_op(ccl_pkg::F_NEXT, 32'd0);             // step off the back
		send_op(ccl_pkg::F_BACK, 32'd0);
		send_op(ccl_pkg::F_INSBEFORE, 32'h8000_0000);
		send_op(ccl_pkg::F_PREPEND, 32'h7FFF_FFFF);   // cursor index moves up
		send_op(ccl_pkg::F_DELFRONT, 32'd0);          // and back down
		send_op(ccl_pkg::F_DELBACK, 32'd0);           // cursor on back: dropped
		send_op(ccl_pkg::F_FRONT, 32'd0);
		send_op(ccl_pkg::F_INSAFTER, 32'hA5A5_A5A5);
		send_op(ccl_pkg::F_SET, 32'h5A5A_5A5A);
		send_op(ccl_pkg::F_DELFRONT, 32'd0);          // cursor on front: dropped
		send_op(ccl_pkg::F_NEXT, 32'd0);
		send_op(ccl_pkg::F_DELCURSOR, 32'd0);
	endtask

	// fill to capacity, full-list failures, drain through the free list
	task automatic test_full();
		send_op(ccl_pkg::F_CLEAR, 32'd0);
		for (int i = 0; i < CAP; i++)
			send_op($urandom_range(0, 1) ? ccl_pkg::F_APPEND : ccl_pkg::F_PREPEND, $urandom);
		send_op(ccl_pkg::F_FRONT, 32'd0);
		send_op(ccl_pkg::F_PREPEND, 32'd1);
		send_op(ccl_pkg::F_APPEND, 32'd2);
		send_op(ccl_pkg::F_INSBEFORE, 32'd3);
		send_op(ccl_pkg::F_INSAFTER, 32'd4);
		send_op(ccl_pkg::F_BACK, 32'd0);
		for (int i = 0; i < 40; i++)
			send_op(($urandom_range(0, 1)) ? ccl_pkg::F_DELFRONT : ccl_pkg::F_DELCURSOR,
				32'd0);
		for (int i = 0; i < 30; i++)
			send_op(($urandom_range(0, 1)) ? ccl_pkg::F_INSAFTER : ccl_pkg::F_INSBEFORE,
				$urandom);
	endtask

	// random mixes; insert-heavy and delete-heavy phases move the length around
	task automatic test_random(int n_ops);
		logic [3:0] op;
		int grow;
		for (int i = 0; i < n_ops; i++) begin
			grow = (i / 150) % 2;
			case ($urandom_range(0, 9))
				0, 1: op = grow ? ccl_pkg::F_APPEND : ccl_pkg::F_DELFRONT;
				2:    op = grow ? ccl_pkg::F_PREPEND : ccl_pkg::F_DELBACK;
				3:    op = grow ? ccl_pkg::F_INSAFTER : ccl_pkg::F_DELCURSOR;
				4:    op = ccl_pkg::F_INSBEFORE;
				5:    op = $urandom_range(0, 1) ? ccl_pkg::F_NEXT : ccl_pkg::F_PREV;
				6:    op = $urandom_range(0, 1) ? ccl_pkg::F_FRONT : ccl_pkg::F_BACK;
				7:    op = ccl_pkg::F_SET;
				8:    op = ($urandom_range(0, 40) == 0) ? ccl_pkg::F_CLEAR : ccl_pkg::F_READ;
				default: op = 4'($urandom_range(0, 15));
			endcase
			send_op(op, rand_word());
		end
	endtask

	// receiver stops for a long stretch while operations keep coming
	task automatic test_backpressure();
		hold_off = 300;
		for (int i = 0; i < 20; i++)
			send_op(ccl_pkg::F_APPEND, $urandom);
	endtask

	initial begin
		int waited;
		errors = 0;
		hold_off = 0;
		list_reset();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ccl_pkg::F_READ;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full();
		test_backpressure();
		test_random(1360);
		s_tvalid <= 1'b0;

		waited = 0;
		while (pending_views.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_views.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
